@@ rtl/core/q4bdp_pkg.sv @@
package q4bdp_pkg;

  // Default widths handed to the top level
  localparam int ACT_WIDTH_DEF = 16;
  localparam int ACC_WIDTH_DEF = 48;

  // Fixed field widths
  localparam int DOT_WIDTH   = 48;
  localparam int SCALE_WIDTH = 16;
  localparam int BYTE_WIDTH  = 8;
  localparam int NIB_WIDTH   = 4;

  // Extra bits of the exact block sum over an activation
  localparam int BSUM_EXTRA = 9;

  // Depth of the close queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Control bits that go with one closed block
  typedef struct packed {
    logic eor;   // block also ends the row
    logic bovf;  // block sum saturated somewhere in this block
  } blk_ctrl_t;

  localparam int CTRL_WIDTH = $bits(blk_ctrl_t);

endpackage

@@ rtl/core/q4bdp_fifo.sv @@
module q4bdp_fifo #(
  parameter int WIDTH = 43,
  parameter int DEPTH = q4bdp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [AW:0]      count_r;

  assign full  = (count_r == (AW+1)'(DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/q4bdp_front.sv @@
module q4bdp_front #(
  parameter int ACT_WIDTH = q4bdp_pkg::ACT_WIDTH_DEF,
  localparam int BSUM_W = ACT_WIDTH + q4bdp_pkg::BSUM_EXTRA
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [q4bdp_pkg::BYTE_WIDTH-1:0] packed_req,
  input  logic signed [ACT_WIDTH-1:0] act_low,
  input  logic signed [ACT_WIDTH-1:0] act_high,
  input  logic                        end_of_block,
  input  logic                        end_of_row,
  output logic                        push,
  output logic signed [BSUM_W-1:0]    push_bsum,
  output q4bdp_pkg::blk_ctrl_t        push_ctrl
);

  localparam int NW = q4bdp_pkg::NIB_WIDTH;
  localparam int PW = ACT_WIDTH + NW;

  logic signed [BSUM_W-1:0] bsum_r;
  logic                     bovf_r;

  logic signed [NW:0]     wl, wh;
  logic signed [PW-1:0]   pl, ph;
  logic signed [BSUM_W:0] sum_wide;
  logic signed [BSUM_W-1:0] sum_sat;
  logic                   sum_ovf;
  logic                   closing;

  // Nibbles to signed weights, offset by half range
  assign wl = $signed({1'b0, packed_req[NW-1:0]}) - $signed((NW+1)'(1 << (NW - 1)));
  assign wh = $signed({1'b0, packed_req[2*NW-1:NW]}) - $signed((NW+1)'(1 << (NW - 1)));

  // Two products and the running block sum
  assign pl       = PW'(wl) * PW'(act_low);
  assign ph       = PW'(wh) * PW'(act_high);
  assign sum_wide = (BSUM_W+1)'(bsum_r) + (BSUM_W+1)'(pl) + (BSUM_W+1)'(ph);

  // Saturate to the block sum width
  assign sum_ovf = (sum_wide[BSUM_W] != sum_wide[BSUM_W-1]);
  assign sum_sat = sum_ovf ? {sum_wide[BSUM_W], {(BSUM_W-1){~sum_wide[BSUM_W]}}}
                           : sum_wide[BSUM_W-1:0];

  assign closing = end_of_block | end_of_row;

  // Closing beat hands the block to the queue
  assign push           = accept & closing;
  assign push_bsum      = sum_sat;
  assign push_ctrl.eor  = end_of_row;
  assign push_ctrl.bovf = bovf_r | sum_ovf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsum_r <= '0;
      bovf_r <= 1'b0;
    end else if (accept) begin
      if (closing) begin
        bsum_r <= '0;
        bovf_r <= 1'b0;
      end else begin
        bsum_r <= sum_sat;
        bovf_r <= bovf_r | sum_ovf;
      end
    end
  end

endmodule

@@ rtl/core/q4bdp_back.sv @@
module q4bdp_back #(
  parameter int ACT_WIDTH = q4bdp_pkg::ACT_WIDTH_DEF,
  parameter int ACC_WIDTH = q4bdp_pkg::ACC_WIDTH_DEF,
  localparam int BSUM_W = ACT_WIDTH + q4bdp_pkg::BSUM_EXTRA
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  logic signed [BSUM_W-1:0]     q_bsum,
  input  logic [q4bdp_pkg::SCALE_WIDTH-1:0] q_scale,
  input  q4bdp_pkg::blk_ctrl_t         q_ctrl,
  output logic                         q_pop,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [q4bdp_pkg::DOT_WIDTH-1:0] out_dot,
  output logic                         out_ovf
);

  localparam int DW      = q4bdp_pkg::DOT_WIDTH;
  localparam int MANT_W  = 10;
  localparam int EXP_W   = 5;
  localparam int MULT_W  = MANT_W + 1;
  localparam int MULW    = BSUM_W + MULT_W;
  localparam int MAX_LSH = 17;
  localparam int SHW     = MULW + MAX_LSH;
  localparam int CW      = ((SHW > ACC_WIDTH) ? SHW : ACC_WIDTH) + 1;

  localparam logic [EXP_W-1:0] EXP_INF  = 5'd31;
  localparam logic [EXP_W-1:0] EXP_ZERO = 5'd0;
  localparam logic [EXP_W-1:0] EXP_UNIT = 5'd13;  // exponent where scale*2^12 = mantissa with hidden bit
  localparam logic [3:0]       SUBN_RSH = 4'd12;

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_MUL   = 4'b0010,
    B_SHIFT = 4'b0100,
    B_ADD   = 4'b1000
  } back_state_t;

  back_state_t state_r;

  logic [EXP_W-1:0]  e_r;
  logic              neg_r;
  logic              eor_r;
  logic [BSUM_W-1:0] mag_r;
  logic [MULT_W-1:0] mult_r;
  logic [MULW-1:0]   prod_r;
  logic [ACC_WIDTH-1:0] tmag_r;

  logic signed [ACC_WIDTH-1:0] acc_r;
  logic                        rovf_r;
  logic                        out_valid_r;
  logic [DW-1:0]               dot_r;
  logic                        ovf_r;

  // Entry decode
  logic [EXP_W-1:0]  q_e;
  logic [BSUM_W-1:0] q_bs_u;
  logic [BSUM_W-1:0] q_mag;

  assign q_e    = q_scale[MANT_W +: EXP_W];
  assign q_bs_u = q_bsum;
  assign q_mag  = q_bsum[BSUM_W-1] ? (~q_bs_u + BSUM_W'(1)) : q_bs_u;
  assign q_pop  = (state_r == B_IDLE) && !q_empty;

  // Shift by the scale exponent, with rounding on the right
  logic [EXP_W-1:0] lsh;
  logic [3:0]       rsh;
  logic [CW-1:0]    wide;
  logic [CW-1:0]    lim;
  logic             term_sat;

  assign lsh = e_r - EXP_UNIT;
  assign rsh = (e_r == EXP_ZERO) ? SUBN_RSH : 4'(EXP_UNIT - e_r);
  assign lim = neg_r ? (CW'(1) << (ACC_WIDTH - 1))
                     : ((CW'(1) << (ACC_WIDTH - 1)) - CW'(1));

  always_comb begin
    if (e_r >= EXP_UNIT) begin
      wide = CW'(prod_r) << lsh;
    end else begin
      wide = (CW'(prod_r) + (CW'(1) << (rsh - 4'd1))) >> rsh;
    end
  end

  assign term_sat = (wide > lim);

  // Signed term and saturating accumulate
  logic signed [ACC_WIDTH-1:0] term;
  logic signed [ACC_WIDTH:0]   acc_wide;
  logic signed [ACC_WIDTH-1:0] acc_sat;
  logic                        acc_ovf;
  logic                        out_free;

  assign term     = neg_r ? -$signed(tmag_r) : $signed(tmag_r);
  assign acc_wide = (ACC_WIDTH+1)'(acc_r) + (ACC_WIDTH+1)'(term);
  assign acc_ovf  = (acc_wide[ACC_WIDTH] != acc_wide[ACC_WIDTH-1]);
  assign acc_sat  = acc_ovf ? {acc_wide[ACC_WIDTH], {(ACC_WIDTH-1){~acc_wide[ACC_WIDTH]}}}
                            : acc_wide[ACC_WIDTH-1:0];
  assign out_free = !out_valid_r || out_tready;

  // Sequencer over one closed block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      acc_r   <= '0;
      rovf_r  <= 1'b0;
    end else begin
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            rovf_r  <= rovf_r | q_ctrl.bovf | (q_e == EXP_INF);
            state_r <= B_MUL;
          end
        end
        B_MUL: begin
          state_r <= B_SHIFT;
        end
        B_SHIFT: begin
          if (e_r != EXP_INF && term_sat) begin
            rovf_r <= 1'b1;
          end
          state_r <= B_ADD;
        end
        B_ADD: begin
          if (!eor_r) begin
            acc_r   <= acc_sat;
            rovf_r  <= rovf_r | acc_ovf;
            state_r <= B_IDLE;
          end else if (out_free) begin
            acc_r   <= '0;
            rovf_r  <= 1'b0;
            state_r <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      e_r    <= q_e;
      neg_r  <= q_bsum[BSUM_W-1] ^ q_scale[MANT_W + EXP_W];
      eor_r  <= q_ctrl.eor;
      mag_r  <= q_mag;
      mult_r <= {(q_e != EXP_ZERO), q_scale[MANT_W-1:0]};
    end
    if (state_r == B_MUL) begin
      prod_r <= MULW'(mag_r) * MULW'(mult_r);
    end
    if (state_r == B_SHIFT) begin
      if (e_r == EXP_INF) begin
        tmag_r <= '0;
      end else if (term_sat) begin
        tmag_r <= lim[ACC_WIDTH-1:0];
      end else begin
        tmag_r <= wide[ACC_WIDTH-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == B_ADD && eor_r && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_ADD && eor_r && out_free) begin
      dot_r <= DW'(acc_sat);
      ovf_r <= rovf_r | acc_ovf;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_dot    = dot_r;
  assign out_ovf    = ovf_r;

endmodule

@@ rtl/core/q4_block_dot_product_unit.sv @@
// Q4 block dot product unit.
// Input beats (in_*) carry one packed weight byte of a 4-bit quantized block,
// the raw f16 block scale and two Q3.12 activations; in_tuser marks the last
// byte of a block and in_tlast the last byte of a row (it also closes the
// block). Each beat adds both weight*activation products to an exact block
// sum. A closing beat queues the block for scaling into a 48-bit accumulator
// with 24 fractional bits; out_* delivers one beat per row: the dot product
// and an overflow flag (saturation or a scale with an all-ones exponent).
// Throughput: one input beat per cycle while the close queue has room. The
// back end takes each closed block through pop, multiply, shift and add and
// pops the next block only after its add; the queue absorbs bursts of short
// blocks in the meantime.
// Reset clears the block sum, accumulator, flags and queue. When the receiver
// stalls, the result waits in the output register; the back end holds the
// next row end, the queue fills, and only then is in_tready dropped.
module q4_block_dot_product_unit #(
  parameter int ACT_WIDTH = q4bdp_pkg::ACT_WIDTH_DEF,
  parameter int ACC_WIDTH = q4bdp_pkg::ACC_WIDTH_DEF,
  localparam int IN_BITS = q4bdp_pkg::SCALE_WIDTH + q4bdp_pkg::BYTE_WIDTH + 2 * ACT_WIDTH,
  localparam int IN_DW   = ((IN_BITS + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [IN_DW-1:0]             in_tdata,  // scale_bits, packed_req, act_low, act_high
  input  logic                         in_tuser,  // end_of_block
  input  logic                         in_tlast,  // end_of_row
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [q4bdp_pkg::DOT_WIDTH-1:0] out_tdata, // dot
  output logic                         out_tuser  // overflow
);

  localparam int SW     = q4bdp_pkg::SCALE_WIDTH;
  localparam int BW     = q4bdp_pkg::BYTE_WIDTH;
  localparam int BSUM_W = ACT_WIDTH + q4bdp_pkg::BSUM_EXTRA;
  localparam int CTW    = q4bdp_pkg::CTRL_WIDTH;
  localparam int QW     = BSUM_W + SW + CTW;

  // Field unpack
  logic [SW-1:0]               scale_bits;
  logic [BW-1:0]               packed_req;
  logic signed [ACT_WIDTH-1:0] act_low;
  logic signed [ACT_WIDTH-1:0] act_high;

  assign scale_bits = in_tdata[SW-1:0];
  assign packed_req = in_tdata[SW +: BW];
  assign act_low    = in_tdata[SW + BW +: ACT_WIDTH];
  assign act_high   = in_tdata[SW + BW + ACT_WIDTH +: ACT_WIDTH];

  logic q_full, q_empty, q_pop, push, accept;
  logic signed [BSUM_W-1:0] push_bsum;
  q4bdp_pkg::blk_ctrl_t     push_ctrl;
  logic [QW-1:0]            q_din, q_dout;

  assign in_tready = !q_full;
  assign accept    = in_tvalid & !q_full;

  // Front: products and block sums
  q4bdp_front #(
    .ACT_WIDTH (ACT_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .packed_req   (packed_req),
    .act_low      (act_low),
    .act_high     (act_high),
    .end_of_block (in_tuser),
    .end_of_row   (in_tlast),
    .push         (push),
    .push_bsum    (push_bsum),
    .push_ctrl    (push_ctrl)
  );

  // Close queue: block sum, scale and control bits
  assign q_din = {push_ctrl, scale_bits, push_bsum};

  q4bdp_fifo #(
    .WIDTH (QW),
    .DEPTH (q4bdp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  // Back: scaling and row accumulation
  q4bdp_back #(
    .ACT_WIDTH (ACT_WIDTH),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_bsum     (q_dout[BSUM_W-1:0]),
    .q_scale    (q_dout[BSUM_W +: SW]),
    .q_ctrl     (q4bdp_pkg::blk_ctrl_t'(q_dout[BSUM_W + SW +: CTW])),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_dot    (out_tdata),
    .out_ovf    (out_tuser)
  );

endmodule

@@ test/tb_q4_block_dot_product_unit.sv @@
`timescale 1ns / 100ps

module tb_q4_block_dot_product_unit;

  localparam int IN_BITS  = q4bdp_pkg::SCALE_WIDTH + q4bdp_pkg::BYTE_WIDTH
                            + 2 * q4bdp_pkg::ACT_WIDTH_DEF;
  localparam int IN_DW    = ((IN_BITS + 7) / 8) * 8;
  localparam int BSUM_W   = q4bdp_pkg::ACT_WIDTH_DEF + q4bdp_pkg::BSUM_EXTRA;
  localparam int FRAC_SH  = 13;   // normal scale: shift is exponent minus this
  localparam int SUB_SH   = 12;   // subnormal scale: fixed right shift
  localparam int EXP_SPECIAL = 31;
  localparam int NIB_BIAS = 8;
  localparam int HIDDEN   = 1024;
  localparam longint unsigned ACC_LIM = (64'd1 << (q4bdp_pkg::ACC_WIDTH_DEF - 1)) - 64'd1;
  localparam longint ACC_MAX_S = longint'(ACC_LIM);
  localparam longint ACC_MIN_S = -ACC_MAX_S - 1;
  localparam longint BSUM_MAX  = (64'sd1 <<< (BSUM_W - 1)) - 1;
  localparam longint BSUM_MIN  = -BSUM_MAX - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 325;

  // one weight beat
  typedef struct {
    bit [15:0]        scale;
    bit [7:0]         wbyte;
    bit signed [15:0] act_lo;
    bit signed [15:0] act_hi;
    bit               eob;
    bit               eor;
  } wbeat_t;

  // one row result
  typedef struct {
    bit [q4bdp_pkg::DOT_WIDTH-1:0] dot;
    bit                            ovf;
  } row_result_t;

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_DW-1:0] in_tdata   = '0;
  logic             in_tuser   = 1'b0;
  logic             in_tlast   = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [q4bdp_pkg::DOT_WIDTH-1:0] out_tdata;
  logic             out_tuser;

  // predictor state
  longint      blk_sum;
  longint      row_sum;
  bit          row_ovf;
  row_result_t pending_rows[$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int errors    = 0;
  int cycles    = 0;

  q4_block_dot_product_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rows outstanding", cycles, pending_rows.size());
      $display("tb_q4_block_dot_product_unit: done, errors");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  // scale a closed block sum by its f16 scale and fold it into the row
  function automatic void fold_block(bit [15:0] h);
    bit [4:0]        ex;
    bit [9:0]        man;
    bit              neg;
    longint          bs;
    longint unsigned mag;
    longint unsigned lim;
    longint          term;
    int              sh;
    ex  = h[14:10];
    man = h[9:0];
    neg = h[15];
    bs  = blk_sum;
    blk_sum = 0;
    // inf / NaN scale: flag and skip the block
    if (ex == EXP_SPECIAL) begin
      row_ovf = 1'b1;
      return;
    end
    if (bs < 0) begin
      neg = !neg;
      mag = longint'(-bs);
    end else begin
      mag = longint'(bs);
    end
    if (ex != 0) begin
      mag = mag * (longint'(HIDDEN) + longint'(man));
      sh  = int'(ex) - FRAC_SH;
    end else begin
      mag = mag * longint'(man);
      sh  = -SUB_SH;
    end
    lim = neg ? ACC_LIM + 64'd1 : ACC_LIM;
    if (sh >= 0) begin
      if (mag > (lim >> sh)) begin
        mag = lim;
        row_ovf = 1'b1;
      end else begin
        mag = mag << sh;
      end
    end else begin
      // round half away from zero on the magnitude
      mag = (mag + (64'd1 << (-sh - 1))) >> (-sh);
      if (mag > lim) begin
        mag = lim;
        row_ovf = 1'b1;
      end
    end
    term = neg ? -longint'(mag) : longint'(mag);
    // saturating accumulate
    if (term > 0 && row_sum > ACC_MAX_S - term) begin
      row_sum = ACC_MAX_S;
      row_ovf = 1'b1;
    end else if (term < 0 && row_sum < ACC_MIN_S - term) begin
      row_sum = ACC_MIN_S;
      row_ovf = 1'b1;
    end else begin
      row_sum = row_sum + term;
    end
  endfunction

  // predict one accepted beat
  function automatic void fold_beat(wbeat_t b);
    longint      wl;
    longint      wh;
    row_result_t r;
    wl = longint'(b.wbyte[3:0]) - NIB_BIAS;
    wh = longint'(b.wbyte[7:4]) - NIB_BIAS;
    blk_sum = blk_sum + wl * longint'(b.act_lo) + wh * longint'(b.act_hi);
    if (blk_sum > BSUM_MAX) begin
      blk_sum = BSUM_MAX;
      row_ovf = 1'b1;
    end else if (blk_sum < BSUM_MIN) begin
      blk_sum = BSUM_MIN;
      row_ovf = 1'b1;
    end
    if (b.eob || b.eor) fold_block(b.scale);
    if (b.eor) begin
      r.dot = row_sum[q4bdp_pkg::DOT_WIDTH-1:0];
      r.ovf = row_ovf;
      pending_rows.push_back(r);
      blk_sum = 0;
      row_sum = 0;
      row_ovf = 1'b0;
    end
  endfunction

  task automatic flag_error(string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // result checker; a beat seen here completes at the next rising edge
  always @(negedge clk) begin
    row_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_rows.size() == 0) begin
        flag_error($sformatf("row result with none pending: dot=%0d ovf=%0b",
                             $signed(out_tdata), out_tuser));
      end else begin
        want = pending_rows.pop_front();
        if (out_tdata !== want.dot)
          flag_error($sformatf("dot mismatch: want %0d got %0d",
                               $signed(want.dot), $signed(out_tdata)));
        if (out_tuser !== want.ovf)
          flag_error($sformatf("overflow mismatch: want %0b got %0b", want.ovf, out_tuser));
      end
    end
  end

  // drive one beat, with random gaps ahead of it, and predict on acceptance
  task automatic send_beat(wbeat_t b);
    bit took;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b.act_hi, b.act_lo, b.wbyte, b.scale};
    in_tuser  <= b.eob;
    in_tlast  <= b.eor;
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
    fold_beat(b);
  endtask

  function automatic wbeat_t mk_beat(bit [15:0] sc, bit [7:0] w, int lo, int hi,
                                     bit eob, bit eor);
    wbeat_t b;
    b.scale  = sc;
    b.wbyte  = w;
    b.act_lo = 16'(lo);
    b.act_hi = 16'(hi);
    b.eob    = eob;
    b.eor    = eor;
    return b;
  endfunction

  // hold off the sender until every row result is back
  task automatic wait_rows_done();
    in_tvalid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // field extremes, both end flags on one beat, row end without block flag
  task automatic test_extremes();
    send_beat(mk_beat(16'h3C00, 8'h00, -32768, -32768, 1'b1, 1'b1));
    send_beat(mk_beat(16'hBC00, 8'hFF, 32767, 32767, 1'b0, 1'b1));
    send_beat(mk_beat(16'h3C00, 8'h88, 12345, -23456, 1'b1, 1'b0));
    send_beat(mk_beat(16'h3C00, 8'hF0, -32768, 32767, 1'b0, 1'b1));
  endtask

  // zero, subnormal, smallest normal, infinite and NaN scales
  task automatic test_scale_classes();
    send_beat(mk_beat(16'h0000, 8'h3C, 1000, -2000, 1'b1, 1'b0));
    send_beat(mk_beat(16'h8000, 8'h3C, 1000, -2000, 1'b1, 1'b0));
    send_beat(mk_beat(16'h0001, 8'h3C, 1000, -2000, 1'b1, 1'b0));
    send_beat(mk_beat(16'h03FF, 8'h3C, 1000, -2000, 1'b1, 1'b0));
    send_beat(mk_beat(16'h0400, 8'h3C, 1000, -2000, 1'b1, 1'b0));
    send_beat(mk_beat(16'hC400, 8'h3C, 1000, -2000, 1'b0, 1'b1));
    send_beat(mk_beat(16'h7C00, 8'h3C, 1000, -2000, 1'b1, 1'b0));
    send_beat(mk_beat(16'hFE01, 8'h3C, 1000, -2000, 1'b0, 1'b1));
  endtask

  // accumulator overflow, then a term that is too large on its own
  task automatic test_saturation();
    send_beat(mk_beat(16'h7BFF, 8'h00, -32768, -32768, 1'b1, 1'b0));
    send_beat(mk_beat(16'h7BFF, 8'h00, -32768, -32768, 1'b1, 1'b0));
    send_beat(mk_beat(16'h3C00, 8'h88, 0, 0, 1'b0, 1'b1));
    send_beat(mk_beat(16'hFBFF, 8'h00, -32768, -32768, 1'b0, 1'b0));
    send_beat(mk_beat(16'hFBFF, 8'h00, -32768, -32768, 1'b0, 1'b1));
  endtask

  // subnormal scale, halfway cases round away from zero
  task automatic test_subnormal_rounding();
    send_beat(mk_beat(16'h0200, 8'h09, 4, 0, 1'b1, 1'b0));
    send_beat(mk_beat(16'h0200, 8'h09, -4, 0, 1'b1, 1'b0));
    send_beat(mk_beat(16'h0200, 8'h09, 12, 0, 1'b0, 1'b1));
  endtask

  function automatic bit [15:0] pick_scale();
    int       r;
    bit [4:0] ex;
    r = $urandom_range(99);
    if (r < 55)      ex = 5'($urandom_range(20, 8));
    else if (r < 70) ex = 5'd0;
    else if (r < 82) ex = 5'($urandom_range(30, 21));
    else if (r < 87) ex = 5'(EXP_SPECIAL);
    else             ex = 5'($urandom_range(31, 0));
    return {1'($urandom_range(1)), ex, 10'($urandom)};
  endfunction

  // content styles: 0 full range, 1 small activations, 2 worst-case magnitude
  function automatic wbeat_t pick_beat(int style, bit [15:0] sc, bit sgn);
    wbeat_t b;
    b = mk_beat(sc, 8'($urandom), int'($urandom), int'($urandom), 1'b0, 1'b0);
    if (style == 1) begin
      b.act_lo = 16'($urandom_range(128) - 64);
      b.act_hi = 16'($urandom_range(128) - 64);
    end else if (style == 2) begin
      b.wbyte  = 8'h00;
      b.act_lo = sgn ? 16'sh8000 : 16'sh7FFF;
      b.act_hi = sgn ? 16'sh8000 : 16'sh7FFF;
    end
    return b;
  endfunction

  // rows of well-formed blocks with random content, plus short, overlong
  // and split blocks
  task automatic test_random_traffic(int idle, int stall, int n_items);
    int          sent;
    int          nblk;
    int          len;
    int          style;
    int          r;
    bit          sgn;
    bit [15:0]   sc;
    wbeat_t      b;
    idle_pct  = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      nblk = $urandom_range(4, 1);
      for (int k = 0; k < nblk; k++) begin
        r = $urandom_range(99);
        if (r < 85)      len = 16;
        else if (r < 93) len = $urandom_range(15, 1);
        else             len = $urandom_range(48, 17);
        r = $urandom_range(99);
        style = (r < 60) ? 0 : (r < 80) ? 1 : 2;
        sgn = 1'($urandom_range(1));
        sc  = pick_scale();
        for (int i = 0; i < len; i++) begin
          b = pick_beat(style, sc, sgn);
          if (i == len - 1) begin
            b.eor = (k == nblk - 1);
            b.eob = b.eor ? 1'($urandom_range(1)) : 1'b1;
          end else begin
            b.eob = ($urandom_range(99) < 2);
          end
          send_beat(b);
          sent++;
        end
      end
    end
    wait_rows_done();
  endtask

  initial begin
    blk_sum = 0;
    row_sum = 0;
    row_ovf = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_scale_classes();
    test_saturation();
    test_subnormal_rounding();
    wait_rows_done();

    test_random_traffic(0, 0, PHASE_ITEMS);
    test_random_traffic(79, 0, PHASE_ITEMS);
    test_random_traffic(0, 79, PHASE_ITEMS);
    test_random_traffic(25, 25, PHASE_ITEMS);

    idle_pct  = 0;
    stall_pct = 0;
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("tb_q4_block_dot_product_unit: done, clean");
    end else begin
      $display("tb_q4_block_dot_product_unit: done, errors");
    end
    $finish;
  end

endmodule
